// ===== src/m6502_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// m6502_pkg
// Shared types and constants for the group-one executor.
// ---------------------------------------------------------------------------
package m6502_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_EXEC  = 2'd2;

    localparam logic [2:0] GRP_ORA = 3'd0;
    localparam logic [2:0] GRP_AND = 3'd1;
    localparam logic [2:0] GRP_EOR = 3'd2;
    localparam logic [2:0] GRP_ADC = 3'd3;
    localparam logic [2:0] GRP_STA = 3'd4;
    localparam logic [2:0] GRP_LDA = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd6;
    localparam logic [2:0] GRP_BAD = 3'd7;

    localparam logic [2:0] MODE_IZX = 3'd0;
    localparam logic [2:0] MODE_ZP  = 3'd1;
    localparam logic [2:0] MODE_IMM = 3'd2;
    localparam logic [2:0] MODE_ABS = 3'd3;
    localparam logic [2:0] MODE_IZY = 3'd4;
    localparam logic [2:0] MODE_ZPX = 3'd5;
    localparam logic [2:0] MODE_ABY = 3'd6;
    localparam logic [2:0] MODE_ABX = 3'd7;

    localparam logic [7:0] OP_STA_IMM = 8'b1000_1001;

    localparam logic [0:0] CFG_INDEX_X = 1'b0;
    localparam logic [0:0] CFG_INDEX_Y = 1'b1;

    // Result item fields
    typedef struct packed {
        logic       fault;
        logic [15:0] program_counter;
        logic [3:0] status_flags;
        logic [7:0] accumulator;
        logic [7:0] read_data;
    } result_t;

    // Memory access request from sequencer to the memory
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // Register-file update from the sequencer
    typedef struct packed {
        logic        we;
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [15:0] pc;
    } arch_upd_t;

    // ALU: returns {flags, acc}
    function automatic logic [11:0] alu(input logic [2:0] grp, input logic [7:0] a,
                                        input logic [7:0] m, input logic [3:0] f);
        logic [8:0] sum;
        logic [7:0] r;
        logic [3:0] nf;
        begin
            sum = 9'd0;
            r   = a;
            nf  = f;
            case (grp)
                GRP_ORA: r = a | m;
                GRP_AND: r = a & m;
                GRP_EOR: r = a ^ m;
                GRP_ADC:
                begin
                    sum   = {1'b0, a} + {1'b0, m} + {8'd0, f[2]};
                    r     = sum[7:0];
                    nf[2] = sum[8];
                    nf[3] = (~(a[7] ^ m[7])) & (a[7] ^ r[7]);
                end
                GRP_LDA: r = m;
                GRP_CMP:
                begin
                    sum   = {1'b0, a} - {1'b0, m};
                    nf[2] = ~sum[8];
                end
                default: r = a;
            endcase
            if (grp == GRP_CMP)
            begin
                nf[0] = (sum[7:0] == 8'd0);
                nf[1] = sum[7];
                alu   = {nf, a};
            end
            else
            begin
                nf[0] = (r == 8'd0);
                nf[1] = r[7];
                alu   = {nf, r};
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/mos6502_group_one_executor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mos6502_group_one_executor
// 6502 group-one instruction executor with its own byte memory.
// ---------------------------------------------------------------------------
// Input items on s_axis: write a memory byte, read one, or execute the
// instruction at the program counter. One result item leaves on m_axis per
// input item, carrying the read byte, A, flags, PC and a fault bit.
// Index registers X and Y are written on the cfg channel; the user must
// write them only while idle, as the block does not enforce it. Execution
// steps through dependent reads of opcode, operand bytes, pointer bytes
// and data via the single memory port. One item is worked on at a time.
// Results sit in an output register; a new item is taken only while that
// register is empty or is being read in the same cycle.
// Reset clears A, flags, PC, X and Y; memory content is undefined until
// written. A receiver stall holds the result and blocks further items.
// ---------------------------------------------------------------------------
module mos6502_group_one_executor #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [17:2] address, [25:18] data, zero fill
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_data, [15:8] accumulator, [19:16] status_flags,
    // [35:20] program_counter, [36] fault, zero fill
    output logic [39:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    m6502_pkg::mem_req_t  req;
    m6502_pkg::arch_upd_t upd;
    m6502_pkg::result_t   res_reg, res_next;
    logic        out_valid_reg;
    logic [7:0]  acc_reg, x_reg, y_reg, rdata, rd_byte;
    logic [3:0]  flag_reg;
    logic [15:0] pc_reg;
    logic        busy, done, fault, start, out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !busy && out_free;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, res_reg};

    m6502_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    m6502_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (s_axis_tdata[1:0]),
        .address (s_axis_tdata[17:2]),
        .data    (s_axis_tdata[25:18]),
        .index_x (x_reg),
        .index_y (y_reg),
        .acc     (acc_reg),
        .flags   (flag_reg),
        .pc      (pc_reg),
        .rdata   (rdata),
        .req     (req),
        .upd     (upd),
        .busy    (busy),
        .done    (done),
        .rd_byte (rd_byte),
        .fault   (fault)
    );

    // Form the result item from the updated registers
    always_comb
    begin
        res_next.read_data       = rd_byte;
        res_next.accumulator     = upd.we ? upd.acc : acc_reg;
        res_next.status_flags    = upd.we ? upd.flags : flag_reg;
        res_next.program_counter = upd.we ? upd.pc : pc_reg;
        res_next.fault           = fault;
    end

    // Hold architectural and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 8'd0;
            flag_reg      <= 4'd0;
            pc_reg        <= 16'd0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.we)
            begin
                acc_reg  <= upd.acc;
                flag_reg <= upd.flags;
                pc_reg   <= upd.pc;
            end
            if (cfg_valid && cfg_index == m6502_pkg::CFG_INDEX_X)
                x_reg <= cfg_data;
            if (cfg_valid && cfg_index == m6502_pkg::CFG_INDEX_Y)
                y_reg <= cfg_data;
            if (done)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid_reg && !m_axis_tready) || $past(start))
        else $error("result overwrote a waiting item");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("item taken while busy");
    a_fault_keep: assert property (@(posedge clk) disable iff (!rst_n)
        fault |-> !upd.we) else $error("faulting item changed state");
`endif
endmodule
`default_nettype wire

// ===== src/m6502_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// m6502_mem
// Single-port byte memory, registered read.
// ---------------------------------------------------------------------------
module m6502_mem #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic               clk,
    input  wire m6502_pkg::mem_req_t req,
    output logic [7:0]              rdata
);
    logic [7:0] mem_array [2**ADDR_BITS];

    // Write or read one byte
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem_array[req.addr[ADDR_BITS-1:0]] <= req.wdata;
            else
                rdata <= mem_array[req.addr[ADDR_BITS-1:0]];
        end
    end
endmodule
`default_nettype wire

// ===== src/m6502_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// m6502_seq
// Item sequencer: fetch, address generation, operand read and execute.
// ---------------------------------------------------------------------------
module m6502_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           func,
    input  wire logic [15:0]          address,
    input  wire logic [7:0]           data,
    input  wire logic [7:0]           index_x,
    input  wire logic [7:0]           index_y,
    input  wire logic [7:0]           acc,
    input  wire logic [3:0]           flags,
    input  wire logic [15:0]          pc,
    input  wire logic [7:0]           rdata,
    output m6502_pkg::mem_req_t       req,
    output m6502_pkg::arch_upd_t      upd,
    output logic                      busy,
    output logic                      done,
    output logic [7:0]                rd_byte,
    output logic                      fault
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_OP   = 9'b000000100,
        S_B1   = 9'b000001000,
        S_B2   = 9'b000010000,
        S_PLO  = 9'b000100000,
        S_PHI  = 9'b001000000,
        S_DAT  = 9'b010000000,
        S_EXE  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  b1_reg, b1_next;
    logic [7:0]  lo_reg, lo_next;
    logic [2:0]  grp, mode;
    logic [15:0] abs_addr;
    logic [15:0] ptr_addr;
    logic [15:0] ea_abs;
    logic [7:0]  zp_ptr;
    logic [11:0] alu_out;

    assign grp      = op_reg[7:5];
    assign mode     = op_reg[4:2];
    assign abs_addr = {rdata, b1_reg};
    assign ptr_addr = {rdata, lo_reg};
    assign ea_abs   = abs_addr + {8'd0, (mode == m6502_pkg::MODE_ABY) ? index_y : index_x};
    assign zp_ptr   = (mode == m6502_pkg::MODE_IZX) ? (b1_reg + index_x) : b1_reg;
    assign alu_out  = m6502_pkg::alu(grp, acc, rdata, flags);
    assign busy     = (state_reg != S_IDLE);

    // Step the sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        b1_next    = b1_reg;
        lo_next    = lo_reg;
        req        = '0;
        upd        = '0;
        upd.acc    = acc;
        upd.flags  = flags;
        upd.pc     = pc;
        done       = 1'b0;
        rd_byte    = 8'd0;
        fault      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        m6502_pkg::FUNC_WRITE:
                        begin
                            req = '{en: 1'b1, we: 1'b1, addr: address, wdata: data};
                            done = 1'b1;
                        end
                        m6502_pkg::FUNC_READ:
                        begin
                            req = '{en: 1'b1, we: 1'b0, addr: address, wdata: 8'd0};
                            state_next = S_RD;
                        end
                        m6502_pkg::FUNC_EXEC:
                        begin
                            req = '{en: 1'b1, we: 1'b0, addr: pc, wdata: 8'd0};
                            state_next = S_OP;
                        end
                        default: done = 1'b1;
                    endcase
                end
            end
            S_RD:
            begin
                rd_byte    = rdata;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_OP:
            begin
                op_next = rdata;
                if (rdata[1:0] != 2'b01 || rdata[7:5] == m6502_pkg::GRP_BAD
                    || rdata == m6502_pkg::OP_STA_IMM)
                begin
                    fault      = 1'b1;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    req = '{en: 1'b1, we: 1'b0, addr: pc + 16'd1, wdata: 8'd0};
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                b1_next = rdata;
                case (mode)
                    m6502_pkg::MODE_IMM:
                    begin
                        upd.we = 1'b1;
                        upd.pc = pc + 16'd2;
                        {upd.flags, upd.acc} = alu_out;
                        done = 1'b1;
                        state_next = S_IDLE;
                    end
                    m6502_pkg::MODE_ABS, m6502_pkg::MODE_ABY, m6502_pkg::MODE_ABX:
                    begin
                        req = '{en: 1'b1, we: 1'b0, addr: pc + 16'd2, wdata: 8'd0};
                        state_next = S_B2;
                    end
                    m6502_pkg::MODE_IZX, m6502_pkg::MODE_IZY:
                    begin
                        req = '{en: 1'b1, we: 1'b0, wdata: 8'd0,
                                addr: {8'd0, (mode == m6502_pkg::MODE_IZX)
                                       ? rdata + index_x : rdata}};
                        state_next = S_PLO;
                    end
                    default:
                    begin
                        req.addr = {8'd0, (mode == m6502_pkg::MODE_ZPX)
                                    ? rdata + index_x : rdata};
                        state_next = S_DAT;
                    end
                endcase
            end
            S_B2:
            begin
                req.addr   = (mode == m6502_pkg::MODE_ABS) ? abs_addr : ea_abs;
                state_next = S_DAT;
            end
            S_PLO:
            begin
                lo_next    = rdata;
                req        = '{en: 1'b1, we: 1'b0, addr: {8'd0, zp_ptr + 8'd1}, wdata: 8'd0};
                state_next = S_PHI;
            end
            S_PHI:
            begin
                req.addr   = (mode == m6502_pkg::MODE_IZY) ? ptr_addr + {8'd0, index_y}
                                                           : ptr_addr;
                state_next = S_DAT;
            end
            S_DAT:
            begin
                state_next = S_EXE;
            end
            S_EXE:
            begin
                upd.we = 1'b1;
                upd.pc = pc + ((mode[0] || mode == m6502_pkg::MODE_ABY) &&
                               mode != m6502_pkg::MODE_ZP && mode != m6502_pkg::MODE_ZPX
                               ? 16'd3 : 16'd2);
                if (grp != m6502_pkg::GRP_STA)
                    {upd.flags, upd.acc} = alu_out;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // Issue the operand access once the effective address is known
        if (state_next == S_DAT && state_reg != S_DAT)
        begin
            req.en    = 1'b1;
            req.we    = (grp == m6502_pkg::GRP_STA);
            req.wdata = acc;
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        b1_reg <= b1_next;
        lo_reg <= lo_next;
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == S_IDLE) else $error("sequencer not idle after item");
    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        upd.we |-> done) else $error("register update outside item end");
    a_fault_op: assert property (@(posedge clk) disable iff (!rst_n)
        fault |-> state_reg == S_OP) else $error("fault outside opcode decode");
`endif
endmodule
`default_nettype wire

// ===== test/tb_mos6502_group_one_executor.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mos6502_group_one_executor
// Self-checking bench for the group-one executor: memory writes, reads and
// single-instruction execution are driven on the input stream, a shadow
// machine predicts each result item and the output stream is compared
// against it item by item, mostly under random idling on both sides.
// ---------------------------------------------------------------------------

class exec_scoreboard;
    bit [7:0]  mem [65536];
    bit        written [65536];
    bit [7:0]  acc;
    bit [3:0]  flags;
    bit [15:0] pc;
    bit [7:0]  ix;
    bit [7:0]  iy;
    m6502_pkg::result_t pending [$];
    int        errors;

    function bit [15:0] zp_pointer(bit [7:0] zp);
        bit [7:0] zp_hi;
        zp_hi = zp + 8'd1;
        return {mem[zp_hi], mem[zp]};
    endfunction

    // Effective address of the instruction at the current PC
    function bit [15:0] eff_addr(bit [7:0] op);
        bit [7:0]  b1;
        bit [7:0]  b2;
        bit [7:0]  zsum;
        bit [15:0] ea;
        b1 = mem[pc + 16'd1];
        b2 = mem[pc + 16'd2];
        zsum = b1 + ix;
        ea = 16'd0;
        case (op[4:2])
            m6502_pkg::MODE_IZX: ea = zp_pointer(zsum);
            m6502_pkg::MODE_ZP:  ea = {8'd0, b1};
            m6502_pkg::MODE_ABS: ea = {b2, b1};
            m6502_pkg::MODE_IZY: ea = zp_pointer(b1) + {8'd0, iy};
            m6502_pkg::MODE_ZPX: ea = {8'd0, zsum};
            m6502_pkg::MODE_ABY: ea = {b2, b1} + {8'd0, iy};
            m6502_pkg::MODE_ABX: ea = {b2, b1} + {8'd0, ix};
            default:  ea = 16'd0;
        endcase
        return ea;
    endfunction

    function void set_zn(bit [7:0] v);
        flags[0] = (v == 8'd0);
        flags[1] = v[7];
    endfunction

    // Returns 1 on an unsupported opcode; state is then untouched
    function bit execute();
        bit [7:0]  op;
        bit [15:0] ea;
        bit [7:0]  m;
        bit [8:0]  sum;
        bit [7:0]  a;
        op = mem[pc];
        if (op[1:0] != 2'b01 || op[7:5] == m6502_pkg::GRP_BAD || op == m6502_pkg::OP_STA_IMM)
            return 1'b1;
        ea = eff_addr(op);
        m = (op[4:2] == m6502_pkg::MODE_IMM) ? mem[pc + 16'd1] : mem[ea];
        a = acc;
        case (op[7:5])
            m6502_pkg::GRP_ORA: begin acc = a | m; set_zn(acc); end
            m6502_pkg::GRP_AND: begin acc = a & m; set_zn(acc); end
            m6502_pkg::GRP_EOR: begin acc = a ^ m; set_zn(acc); end
            m6502_pkg::GRP_ADC:
            begin
                sum = {1'b0, a} + {1'b0, m} + {8'd0, flags[2]};
                acc = sum[7:0];
                set_zn(acc);
                flags[2] = sum[8];
                flags[3] = (~(a[7] ^ m[7])) & (a[7] ^ acc[7]);
            end
            m6502_pkg::GRP_STA:
            begin
                mem[ea] = acc;
                written[ea] = 1'b1;
            end
            m6502_pkg::GRP_LDA: begin acc = m; set_zn(m); end
            default:
            begin
                set_zn(a - m);
                flags[2] = (a >= m);
            end
        endcase
        pc = pc + ((op[4:2] == m6502_pkg::MODE_ABS || op[4:2] >= m6502_pkg::MODE_ABY)
                   ? 16'd3 : 16'd2);
        return 1'b0;
    endfunction

    // Note an accepted input item and queue the result it causes
    function void note_input(bit [1:0] fn, bit [15:0] addr, bit [7:0] data);
        m6502_pkg::result_t r;
        r = '0;
        case (fn)
            m6502_pkg::FUNC_WRITE:
            begin
                mem[addr] = data;
                written[addr] = 1'b1;
            end
            m6502_pkg::FUNC_READ: r.read_data = mem[addr];
            m6502_pkg::FUNC_EXEC: r.fault = execute();
            default: ;
        endcase
        r.accumulator = acc;
        r.status_flags = flags;
        r.program_counter = pc;
        pending.push_back(r);
    endfunction

    // Compare one result item with the oldest expectation
    function void check_result(logic [39:0] tdata);
        m6502_pkg::result_t got;
        m6502_pkg::result_t exp_r;
        got = tdata[36:0];
        if (pending.size() == 0)
        begin
            errors++;
            $display("%t: unexpected result item, expected none, got %h", $realtime, got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r)
        begin
            errors++;
            $display("%t: mismatch exp rd=%h a=%h f=%h pc=%h flt=%b",
                     $realtime, exp_r.read_data, exp_r.accumulator, exp_r.status_flags,
                     exp_r.program_counter, exp_r.fault);
            $display("%t:          got rd=%h a=%h f=%h pc=%h flt=%b",
                     $realtime, got.read_data, got.accumulator, got.status_flags,
                     got.program_counter, got.fault);
        end
    endfunction
endclass

module tb_mos6502_group_one_executor;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;

    exec_scoreboard sb;
    int          tx_idle;
    int          rx_idle;
    int          sent;
    bit [15:0]   known_addr [$];

    mos6502_group_one_executor DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Check result items and stall the receiver at random
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Send one item and note it once accepted
    task automatic send_item(bit [1:0] fn, bit [15:0] addr, bit [7:0] data);
        if ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, data, addr, fn};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(fn, addr, data);
        if (fn == m6502_pkg::FUNC_WRITE)
            known_addr.push_back(addr);
        sent++;
    endtask

    // Hold the sender until every expected result has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_index(logic idx, bit [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == m6502_pkg::CFG_INDEX_X)
            sb.ix = value;
        else
            sb.iy = value;
        @(posedge clk);
    endtask

    function automatic bit [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h80;
            2: return 8'hFF;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Place an instruction at the PC, make sure every byte it reads is
    // written, then execute it
    task automatic run_instr(bit [7:0] op, bit [7:0] b1, bit [7:0] b2);
        bit [15:0] pc;
        bit [7:0]  zp;
        bit [15:0] ea;
        bit        uses_ptr;
        bit        clash;
        pc = sb.pc;
        send_item(m6502_pkg::FUNC_WRITE, pc, op);
        send_item(m6502_pkg::FUNC_WRITE, pc + 16'd1, b1);
        send_item(m6502_pkg::FUNC_WRITE, pc + 16'd2, b2);
        uses_ptr = (op[4:2] == m6502_pkg::MODE_IZX || op[4:2] == m6502_pkg::MODE_IZY);
        zp = (op[4:2] == m6502_pkg::MODE_IZX) ? b1 + sb.ix : b1;
        if (op[1:0] == 2'b01 && uses_ptr)
        begin
            if (!sb.written[{8'd0, zp}])
                send_item(m6502_pkg::FUNC_WRITE, {8'd0, zp}, 8'($urandom));
            if (!sb.written[{8'd0, zp + 8'd1}])
                send_item(m6502_pkg::FUNC_WRITE, {8'd0, zp + 8'd1}, 8'($urandom));
        end
        if (op[1:0] == 2'b01 && op[4:2] != m6502_pkg::MODE_IMM
            && op[7:5] != m6502_pkg::GRP_STA)
        begin
            ea = sb.eff_addr(op);
            clash = (ea == pc || ea == pc + 16'd1 || ea == pc + 16'd2 ||
                     (uses_ptr && (ea == {8'd0, zp} || ea == {8'd0, zp + 8'd1})));
            if (!sb.written[ea] || (!clash && $urandom_range(1)))
                send_item(m6502_pkg::FUNC_WRITE, ea, pick_byte());
        end
        send_item(m6502_pkg::FUNC_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // Random mix: mostly well-formed instructions, some reads and noise
    task automatic random_phase(int target);
        int r;
        bit [7:0] op;
        while (sent < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                if ($urandom_range(9) == 0)
                    op = 8'($urandom);
                else
                    op = {3'($urandom_range(6)), 3'($urandom), 2'b01};
                run_instr(op, pick_byte(), pick_byte());
            end
            else if (r < 85)
                send_item(m6502_pkg::FUNC_READ,
                          known_addr[$urandom_range(known_addr.size() - 1)],
                          8'($urandom));
            else if (r < 95)
                send_item(m6502_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
            else
                send_item(2'd3, 16'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        bit [2:0] grp_of_mode [8];
        sb = new();
        grp_of_mode = '{m6502_pkg::GRP_ORA, m6502_pkg::GRP_AND, m6502_pkg::GRP_EOR,
                        m6502_pkg::GRP_STA, m6502_pkg::GRP_LDA, m6502_pkg::GRP_CMP,
                        m6502_pkg::GRP_ADC, m6502_pkg::GRP_LDA};
        tx_idle = 0;
        rx_idle = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: address extremes, unused func, flag corners, every mode
        set_index(m6502_pkg::CFG_INDEX_X, 8'hFF);
        set_index(m6502_pkg::CFG_INDEX_Y, 8'hFF);
        send_item(m6502_pkg::FUNC_WRITE, 16'hFFFF, 8'hA5);
        send_item(m6502_pkg::FUNC_WRITE, 16'h0000, 8'h5A);
        send_item(m6502_pkg::FUNC_READ, 16'hFFFF, 8'h00);
        send_item(m6502_pkg::FUNC_READ, 16'h0000, 8'hFF);
        send_item(2'd3, 16'hFFFF, 8'hFF);
        run_instr({m6502_pkg::GRP_LDA, m6502_pkg::MODE_IMM, 2'b01}, 8'h00, 8'h00);
        run_instr({m6502_pkg::GRP_LDA, m6502_pkg::MODE_IMM, 2'b01}, 8'h7F, 8'h00);
        run_instr({m6502_pkg::GRP_ADC, m6502_pkg::MODE_IMM, 2'b01}, 8'h01, 8'h00);
        run_instr({m6502_pkg::GRP_ADC, m6502_pkg::MODE_IMM, 2'b01}, 8'hFF, 8'h00);
        run_instr({m6502_pkg::GRP_CMP, m6502_pkg::MODE_IMM, 2'b01}, 8'h7F, 8'h00);
        run_instr({m6502_pkg::GRP_CMP, m6502_pkg::MODE_IMM, 2'b01}, 8'hFF, 8'h00);
        for (int m = 0; m < 8; m++)
            run_instr({grp_of_mode[m], 3'(m), 2'b01}, (m == 0) ? 8'h00 : 8'hFF, 8'hFF);
        run_instr(m6502_pkg::OP_STA_IMM, 8'h00, 8'h00);
        run_instr({m6502_pkg::GRP_BAD, m6502_pkg::MODE_ZP, 2'b01}, 8'h00, 8'h00);
        run_instr(8'hFF, 8'h00, 8'h00);
        run_instr(8'h00, 8'h00, 8'h00);
        drain();

        // Phase one: sender idles less than receiver, zero indexes
        set_index(m6502_pkg::CFG_INDEX_X, 8'h00);
        set_index(m6502_pkg::CFG_INDEX_Y, 8'h00);
        tx_idle = 23;
        rx_idle = 55;
        random_phase(sent + 175);
        drain();
        random_phase(sent + 175);
        drain();

        // Phase two: roles swapped, X index at FF and Y index at 01
        set_index(m6502_pkg::CFG_INDEX_X, 8'hFF);
        set_index(m6502_pkg::CFG_INDEX_Y, 8'h01);
        tx_idle = 55;
        rx_idle = 23;
        random_phase(sent + 350);
        drain();

        // Phase three: no idling, random indexes
        set_index(m6502_pkg::CFG_INDEX_X, 8'($urandom));
        set_index(m6502_pkg::CFG_INDEX_Y, 8'($urandom));
        tx_idle = 0;
        rx_idle = 0;
        random_phase(sent + 350);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/m6502_pkg.sv
src/m6502_mem.sv
src/m6502_seq.sv
src/mos6502_group_one_executor.sv
test/tb_mos6502_group_one_executor.sv
